FILE: rtl/cht_pkg.sv
package cht_pkg;

  localparam int NUM_BUCKETS = 256;
  localparam int POOL_NODES  = 1024;
  localparam int VALUE_BITS  = 32;

  localparam int KEY_W   = 31;
  localparam int CFG_W   = 9;
  localparam int COUNT_W = 11;
  localparam int KIND_W  = 2;
  localparam int NODE_W  = $clog2(POOL_NODES);
  localparam int BKT_W   = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;

  localparam int HASH_STEPS = (KEY_W + 1) / 2;
  localparam int HCNT_W     = (HASH_STEPS > 1) ? $clog2(HASH_STEPS) : 1;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

  localparam logic [CFG_W-1:0] BUCKET_RESET = 9'd256;

  typedef struct packed {
    logic [KEY_W-1:0]      key;
    logic [VALUE_BITS-1:0] value;
    logic [NODE_W-1:0]     next;
    logic                  next_valid;
  } node_t;

endpackage

FILE: rtl/chained_hash_table_top.sv
// Hash table with separate chaining over a pool of cht_pkg::POOL_NODES nodes. The bucket of a
// key is key mod bucket_count (0 taken as 1, above cht_pkg::NUM_BUCKETS saturated). Insert
// pushes a new node at the head of its chain, reusing freed nodes first, and reports status 1
// with nothing changed when the pool is exhausted. Lookup returns the most recent value for a
// key; remove unlinks and frees the first match. One transaction at a time: the modulo is a
// two-bit-per-cycle restoring unit, then an insert reads and writes the bucket head, while a
// lookup or remove reads the head and walks the chain node by node (with a free step after
// a successful remove), each node read being registered in the node memory; the result is then
// registered for output. Bucket heads carry flip-flop valid bits, so no clearing pass follows
// reset. bucket_count may be written only while the block is idle.
module chained_hash_table_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [cht_pkg::KIND_W-1:0]       kind,
  input  logic [cht_pkg::KEY_W-1:0]        key,
  input  logic [cht_pkg::VALUE_BITS-1:0]   value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             found,
  output logic [cht_pkg::VALUE_BITS-1:0]   found_value,
  output logic                             status,
  output logic [cht_pkg::COUNT_W-1:0]      stored_count,
  input  logic                             cfg_we,
  input  logic [cht_pkg::CFG_W-1:0]        cfg_data
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_HASH  = 3'd1;
  localparam logic [2:0] S_HEAD  = 3'd2;
  localparam logic [2:0] S_INS   = 3'd3;
  localparam logic [2:0] S_FIRST = 3'd4;
  localparam logic [2:0] S_WALK  = 3'd5;
  localparam logic [2:0] S_FREE  = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  localparam int RK_W = cht_pkg::CFG_W + 1;

  logic [2:0]                       state;
  logic [cht_pkg::CFG_W-1:0]        bucket_count;
  logic [cht_pkg::KIND_W-1:0]       kind_r;
  logic [cht_pkg::KEY_W-1:0]        key_r;
  logic [cht_pkg::VALUE_BITS-1:0]   value_r;
  logic [cht_pkg::KEY_W:0]          kshift;
  logic [cht_pkg::CFG_W-1:0]        rem;
  logic [cht_pkg::CFG_W-1:0]        modulus;
  logic [cht_pkg::HCNT_W-1:0]       hcnt;
  logic [cht_pkg::BKT_W-1:0]        bucket;

  logic [cht_pkg::NODE_W-1:0]       head_mem [cht_pkg::NUM_BUCKETS];
  logic [cht_pkg::NUM_BUCKETS-1:0]  head_valid;
  logic [cht_pkg::NODE_W-1:0]       head_rd;
  logic                             head_we;
  logic [cht_pkg::NODE_W-1:0]       head_wdata;

  cht_pkg::node_t                   node_mem [cht_pkg::POOL_NODES];
  cht_pkg::node_t                   node_rd;
  cht_pkg::node_t                   node_wdata;
  cht_pkg::node_t                   prev_node;
  cht_pkg::node_t                   cur_node;
  logic                             node_we;
  logic [cht_pkg::NODE_W-1:0]       node_waddr;
  logic [cht_pkg::NODE_W-1:0]       node_raddr;

  logic [cht_pkg::NODE_W-1:0]       free_head;
  logic                             free_valid;
  logic [cht_pkg::NODE_W:0]         unused_mark;
  logic [cht_pkg::COUNT_W-1:0]      entry_count;

  logic [cht_pkg::NODE_W-1:0]       cur;
  logic [cht_pkg::NODE_W-1:0]       prev;
  logic                             has_prev;
  logic [cht_pkg::NODE_W:0]         steps;

  logic                             res_found;
  logic [cht_pkg::VALUE_BITS-1:0]   res_value;
  logic                             res_status;

  logic                             ins_ok;
  logic [cht_pkg::NODE_W-1:0]       new_node;
  logic                             walk_live;
  logic                             match;
  logic [cht_pkg::CFG_W-1:0]        rem_next;

  function automatic logic [cht_pkg::CFG_W-1:0] rem_step(
    input logic [cht_pkg::CFG_W-1:0] r,
    input logic                      b,
    input logic [cht_pkg::CFG_W-1:0] m
  );
    logic [RK_W-1:0] t;
    t = {r, b};
    if (t >= {1'b0, m}) begin
      t = t - {1'b0, m};
    end
    return t[cht_pkg::CFG_W-1:0];
  endfunction

  always_comb begin
    if (bucket_count == '0) begin
      modulus = cht_pkg::CFG_W'(1);
    end else if ({1'b0, bucket_count} > RK_W'(cht_pkg::NUM_BUCKETS)) begin
      modulus = cht_pkg::CFG_W'(cht_pkg::NUM_BUCKETS);
    end else begin
      modulus = bucket_count;
    end
    rem_next = rem_step(rem_step(rem, kshift[cht_pkg::KEY_W], modulus),
                        kshift[cht_pkg::KEY_W-1], modulus);
  end

  assign in_ready  = (state == S_IDLE);
  assign ins_ok    = free_valid || (unused_mark < (cht_pkg::NODE_W+1)'(cht_pkg::POOL_NODES));
  assign new_node  = free_valid ? free_head : unused_mark[cht_pkg::NODE_W-1:0];
  assign walk_live = (steps < (cht_pkg::NODE_W+1)'(cht_pkg::POOL_NODES));
  assign match     = (node_rd.key == key_r);

  always_comb begin
    head_we    = 1'b0;
    head_wdata = node_rd.next;
    node_we    = 1'b0;
    node_waddr = prev;
    node_wdata = '{key: prev_node.key, value: prev_node.value,
                   next: node_rd.next, next_valid: node_rd.next_valid};
    unique case (state)
      S_HEAD:  node_raddr = free_head;
      S_FIRST: node_raddr = head_rd;
      S_WALK:  node_raddr = node_rd.next;
      default: node_raddr = free_head;
    endcase
    unique case (state)
      S_INS: begin
        head_we    = ins_ok;
        head_wdata = new_node;
        node_we    = ins_ok;
        node_waddr = new_node;
        node_wdata = '{key: key_r, value: value_r, next: head_rd,
                       next_valid: head_valid[bucket]};
      end
      S_WALK: begin
        if (walk_live && match && kind_r == cht_pkg::KIND_REMOVE) begin
          node_we = has_prev;
          head_we = !has_prev;
        end
      end
      S_FREE: begin
        node_we    = 1'b1;
        node_waddr = cur;
        node_wdata = '{key: cur_node.key, value: cur_node.value,
                       next: free_head, next_valid: free_valid};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[bucket] <= head_wdata;
    end
    head_rd <= head_mem[bucket];
  end

  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_waddr] <= node_wdata;
    end
    node_rd <= node_mem[node_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= cht_pkg::BUCKET_RESET;
    end else if (cfg_we) begin
      bucket_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      head_valid  <= '0;
      free_valid  <= 1'b0;
      unused_mark <= '0;
      entry_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            kind_r     <= kind;
            key_r      <= key;
            value_r    <= value;
            kshift     <= {1'b0, key};
            rem        <= '0;
            hcnt       <= '0;
            res_found  <= 1'b0;
            res_value  <= '0;
            res_status <= 1'b0;
            state      <= S_HASH;
          end
        end
        S_HASH: begin
          rem    <= rem_next;
          kshift <= {kshift[cht_pkg::KEY_W-2:0], 2'b00};
          hcnt   <= hcnt + 1'b1;
          if (hcnt == cht_pkg::HCNT_W'(cht_pkg::HASH_STEPS - 1)) begin
            bucket <= rem_next[cht_pkg::BKT_W-1:0];
            if (kind_r == cht_pkg::KIND_INSERT || kind_r == cht_pkg::KIND_LOOKUP ||
                kind_r == cht_pkg::KIND_REMOVE) begin
              state <= S_HEAD;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_HEAD: begin
          state <= (kind_r == cht_pkg::KIND_INSERT) ? S_INS : S_FIRST;
        end
        S_INS: begin
          if (ins_ok) begin
            if (free_valid) begin
              free_head  <= node_rd.next;
              free_valid <= node_rd.next_valid;
            end else begin
              unused_mark <= unused_mark + 1'b1;
            end
            head_valid[bucket] <= 1'b1;
            entry_count        <= entry_count + 1'b1;
          end else begin
            res_status <= 1'b1;
          end
          state <= S_DONE;
        end
        S_FIRST: begin
          cur      <= head_rd;
          steps    <= '0;
          has_prev <= 1'b0;
          state    <= head_valid[bucket] ? S_WALK : S_DONE;
        end
        S_WALK: begin
          if (!walk_live) begin
            state <= S_DONE;
          end else if (match) begin
            res_found <= 1'b1;
            res_value <= node_rd.value;
            cur_node  <= node_rd;
            if (kind_r == cht_pkg::KIND_REMOVE) begin
              if (!has_prev) begin
                head_valid[bucket] <= node_rd.next_valid;
              end
              state <= S_FREE;
            end else begin
              state <= S_DONE;
            end
          end else begin
            prev      <= cur;
            prev_node <= node_rd;
            has_prev  <= 1'b1;
            cur       <= node_rd.next;
            steps     <= steps + 1'b1;
            if (!node_rd.next_valid) begin
              state <= S_DONE;
            end
          end
        end
        S_FREE: begin
          free_head  <= cur;
          free_valid <= 1'b1;
          if (entry_count != '0) begin
            entry_count <= entry_count - 1'b1;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            found        <= res_found;
            found_value  <= res_value;
            status       <= res_status;
            stored_count <= entry_count;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_le_mark: assert property (@(posedge clk) disable iff (rst)
    {1'b0, entry_count} <= (cht_pkg::COUNT_W+1)'(unused_mark))
    else $error("entry count exceeds nodes handed out");

  a_mark_le_pool: assert property (@(posedge clk) disable iff (rst)
    unused_mark <= (cht_pkg::NODE_W+1)'(cht_pkg::POOL_NODES))
    else $error("unused mark beyond pool");

  a_free_after_walk: assert property (@(posedge clk) disable iff (rst)
    (state == S_FREE) |-> ($past(state) == S_WALK && kind_r == cht_pkg::KIND_REMOVE))
    else $error("free without a matching remove");

  a_insert_sets_head: assert property (@(posedge clk) disable iff (rst)
    (state == S_INS && ins_ok) |=> head_valid[bucket])
    else $error("insert left bucket empty");
`endif

endmodule
